### hdl/lir_pkg.sv
package lir_pkg;

  // Commands from the sequencer to the datapath, valid for one cycle.
  typedef struct packed {
    logic accept;     // input transfer this cycle
    logic first;      // first sample of a clip: seed held sample, zero phase
    logic emit;       // issue one output at the current phase
    logic run_last;   // issued output is the final one for this input
    logic clip_end;   // issued output closes the clip
    logic roll;       // interval done: phase -= 1.0, held <= new
    logic clear;      // end of clip: drop held sample, zero phase
  } lir_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic have;         // a sample of the current clip is held
    logic last;         // current input is marked last
    logic phase_lt_one; // phase < 1.0
    logic next_ge_one;  // phase + step >= 1.0
    logic next_ge_two;  // phase + step >= 2.0
    logic stall;        // output register full and not taken
  } lir_sts_t;

endpackage

### hdl/lir_if.sv
interface lir_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          last_in;

  modport source (output valid, output sample_in, output last_in, input ready);
  modport sink   (input valid, input sample_in, input last_in, output ready);
endinterface

interface lir_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          run_last;
  logic                          clip_end;

  modport source (output valid, output sample_out, output run_last, output clip_end,
                  input ready);
  modport sink   (input valid, input sample_out, input run_last, input clip_end,
                  output ready);
endinterface

interface lir_cfg_if #(
  parameter int STEP_BITS = 20
);
  logic                 valid;
  logic                 ready;
  logic [STEP_BITS-1:0] rate_step;

  modport source (output valid, output rate_step, input ready);
  modport sink   (input valid, input rate_step, output ready);
endinterface

### hdl/lir_ctrl.sv
module lir_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  input  lir_pkg::lir_sts_t sts,
  output lir_pkg::lir_cmd_t cmd
);
  import lir_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_INTERP = 3'b010,
    ST_FLUSH  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.have) begin
            state_nxt = ST_INTERP;
          end else begin
            cmd.first = 1'b1;
            state_nxt = in_last ? ST_FLUSH : ST_IDLE;
          end
        end
      end
      ST_INTERP: begin
        if (sts.phase_lt_one) begin
          if (!sts.stall) begin
            cmd.emit     = 1'b1;
            cmd.run_last = sts.next_ge_one && (!sts.last || sts.next_ge_two);
            cmd.clip_end = cmd.run_last && sts.last;
          end
        end else begin
          cmd.roll  = 1'b1;
          state_nxt = sts.last ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (sts.phase_lt_one) begin
          if (!sts.stall) begin
            cmd.emit     = 1'b1;
            cmd.run_last = sts.next_ge_one;
            cmd.clip_end = sts.next_ge_one;
          end
        end else begin
          cmd.clear = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hdl/lir_dp.sv
module lir_dp #(
  parameter int SAMPLE_BITS     = 16,
  parameter int PHASE_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lir_pkg::lir_cmd_t                   cmd,
  output lir_pkg::lir_sts_t                   sts,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample,
  input  logic                                in_last,
  input  logic                                cfg_valid,
  input  logic [PHASE_FRAC_BITS+3:0]          cfg_step,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       out_sample,
  output logic                                out_run_last,
  output logic                                out_clip_end
);
  import lir_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int PFB = PHASE_FRAC_BITS;
  localparam int STW = PFB + 4;       // Q4.PFB step
  localparam int PW  = PFB + 5;       // Q5.PFB phase
  localparam int PRW = SB + PFB + 1;  // diff * frac
  localparam int AW  = SB + PFB + 2;  // rounding accumulator

  localparam logic [PW-1:0]  PHASE_ONE = PW'(1) << PFB;
  localparam logic [PW-1:0]  PHASE_TWO = PW'(1) << (PFB + 1);
  localparam logic [STW-1:0] STEP_MIN  = STW'(1) << (PFB - 4);
  localparam logic [STW-1:0] STEP_RST  = STW'(1) << PFB;
  localparam logic [AW-1:0]  HALF_LSB  = AW'(1) << (PFB - 1);

  // state and configuration
  logic [STW-1:0]       rate_step_r;
  logic signed [SB-1:0] held_r;
  logic signed [SB-1:0] new_r;
  logic                 have_r;
  logic                 last_r;
  logic [PW-1:0]        phase_r;

  // multiply stage
  logic                  p1_v_r;
  logic signed [PRW-1:0] p1_prod_r;
  logic signed [SB-1:0]  p1_base_r;
  logic                  p1_run_last_r;
  logic                  p1_clip_end_r;

  // output register
  logic                 out_v_r;
  logic signed [SB-1:0] out_sample_r;
  logic                 out_run_last_r;
  logic                 out_clip_end_r;

  logic [STW-1:0]        step;
  logic [PW-1:0]         phase_next;
  logic signed [SB:0]    diff;
  logic signed [PRW:0]   prod_full;
  logic signed [AW-1:0]  acc;
  logic                  stall;

  assign step       = (rate_step_r < STEP_MIN) ? STEP_MIN : rate_step_r;
  assign phase_next = phase_r + PW'(step);
  assign stall      = out_v_r && !out_ready;

  assign diff      = {new_r[SB-1], new_r} - {held_r[SB-1], held_r};
  assign prod_full = diff * $signed({1'b0, phase_r[PFB-1:0]});

  // held * 1.0 + diff * frac + 0.5, floor by the fraction bits
  assign acc = $signed({{2{p1_base_r[SB-1]}}, p1_base_r, {PFB{1'b0}}})
             + $signed({p1_prod_r[PRW-1], p1_prod_r})
             + $signed(HALF_LSB);

  always_comb begin
    sts              = '0;
    sts.have         = have_r;
    sts.last         = last_r;
    sts.phase_lt_one = phase_r < PHASE_ONE;
    sts.next_ge_one  = phase_next >= PHASE_ONE;
    sts.next_ge_two  = phase_next >= PHASE_TWO;
    sts.stall        = stall;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_step_r <= STEP_RST;
      have_r      <= 1'b0;
      phase_r     <= '0;
      p1_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        rate_step_r <= cfg_step;
      end
      if (cmd.first) begin
        have_r  <= 1'b1;
        phase_r <= '0;
      end else if (cmd.emit) begin
        phase_r <= phase_next;
      end else if (cmd.roll) begin
        phase_r <= phase_r - PHASE_ONE;
      end else if (cmd.clear) begin
        have_r  <= 1'b0;
        phase_r <= '0;
      end
      if (!stall) begin
        p1_v_r  <= cmd.emit;
        out_v_r <= p1_v_r;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      new_r  <= in_sample;
      last_r <= in_last;
    end
    if (cmd.first) begin
      held_r <= in_sample;
    end else if (cmd.roll) begin
      held_r <= new_r;
    end else if (cmd.clear) begin
      held_r <= '0;
    end
    if (!stall && cmd.emit) begin
      p1_prod_r     <= prod_full[PRW-1:0];
      p1_base_r     <= held_r;
      p1_run_last_r <= cmd.run_last;
      p1_clip_end_r <= cmd.clip_end;
    end
    if (!stall && p1_v_r) begin
      out_sample_r   <= acc[PFB+SB-1:PFB];
      out_run_last_r <= p1_run_last_r;
      out_clip_end_r <= p1_clip_end_r;
    end
  end

  assign out_valid    = out_v_r;
  assign out_sample   = out_sample_r;
  assign out_run_last = out_run_last_r;
  assign out_clip_end = out_clip_end_r;

endmodule

### hdl/linear_interp_resampler.sv
// Path from an input transfer to its first result: sequencer, multiply stage, round stage.
// Throughput: one result per cycle while the sequencer runs and the output is not stalled;
//   an input costs its results plus an accept and an interval roll, and a last input a clear.
// Reset (rst_n, synchronous, active low): no sample held, phase zero, rate_step 1.0,
//   pipeline empty. Configuration is taken in any cycle.
module linear_interp_resampler #(
  parameter int SAMPLE_BITS     = 16,
  parameter int PHASE_FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  lir_in_if.sink   in_chan,
  lir_out_if.source out_chan,
  lir_cfg_if.sink  cfg_chan
);
  import lir_pkg::*;

  lir_cmd_t cmd;
  lir_sts_t sts;

  // Register writes complete at once; the step is only read by the datapath.
  assign cfg_chan.ready = 1'b1;

  // Sequencer: accepts an input only in its idle state, then walks the output
  // phase through the current interval and, for a last sample, the end flush.
  lir_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_last  (in_chan.last_in),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: held/new samples, phase accumulator, a multiply stage and a
  // rounding stage that loads the output register. Its stages and output issue
  // stall while the output register waits for a transfer; accept and roll do not.
  lir_dp #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_sample    (in_chan.sample_in),
    .in_last      (in_chan.last_in),
    .cfg_valid    (cfg_chan.valid),
    .cfg_step     (cfg_chan.rate_step),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .out_sample   (out_chan.sample_out),
    .out_run_last (out_chan.run_last),
    .out_clip_end (out_chan.clip_end)
  );

endmodule

### hdl/lir_checker.sv
module lir_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input logic out_run_last,
  input logic out_clip_end,
  input logic cfg_ready
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // clip end only on the last result of an input
  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clip_end |-> out_run_last)
    else $error("clip_end without run_last");

  // a last sample always starts a flush, so input is closed next cycle
  a_last_closes_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input open right after last transfer");

  // configuration never back-pressures
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("cfg ready low");

endmodule

bind linear_interp_resampler lir_checker u_lir_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .in_last      (in_chan.last_in),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_run_last (out_chan.run_last),
  .out_clip_end (out_chan.clip_end),
  .cfg_ready    (cfg_chan.ready)
);

### dv/tb_linear_interp_resampler.sv
module tb_linear_interp_resampler;

  // Widths of the block as built here.
  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 16;
  localparam int STEP_W   = 20;

  // Phase arithmetic, Q.16: one source interval is PHASE_ONE.
  localparam longint PHASE_ONE  = 64'd1 << FRAC_W;
  localparam longint PHASE_HALF = PHASE_ONE >> 1;
  // Steps below 1/16 are raised to 1/16: at most 16 outputs per interval.
  localparam longint STEP_FLOOR = PHASE_ONE >> 4;
  // 16 interpolated plus 16 flushed outputs per input, worst case.
  localparam int MAX_PER_INPUT = 32;
  localparam logic [STEP_W-1:0] RATE_AT_RESET = 20'd65536;

  // Stimulus shape.
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_ITEMS  = 35;   // 12 x 35 = 420 random samples
  localparam int HOLD_PHASE   = 2;    // receiver backs off for a long stretch here
  localparam int QUIET_PHASE  = 5;    // no idling on either side here
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_PCT     = 6;
  // Pipeline: sequencer, multiply and round stages; give it generous room to settle.
  localparam int SETTLE_CYCLES = 12;
  localparam int TAIL_CYCLES   = 24;
  // Slowest correct run sees no transfer at all for the receiver's long hold-off.
  localparam int STALL_LIMIT   = 4000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       run_last;
    logic                       clip_end;
  } resampled_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the resampler state, predicts the output burst of each
  // accepted input and checks every output transfer against the oldest one.
  // --------------------------------------------------------------------------
  class resampler_scoreboard;
    logic [STEP_W-1:0]          step_reg;
    logic signed [SAMPLE_W-1:0] prev_sample;
    bit                         primed;       // a sample of the open clip is held
    longint                     cursor;       // next output position past prev_sample
    resampled_t                 pending_outs[$];

    function new();
      step_reg    = RATE_AT_RESET;
      prev_sample = '0;
      primed      = 1'b0;
      cursor      = 0;
    endfunction

    function void set_rate(logic [STEP_W-1:0] v);
      step_reg = v;
    endfunction

    function int outstanding();
      return pending_outs.size();
    endfunction

    // a + frac * (b - a), round half up
    function logic signed [SAMPLE_W-1:0] blend(logic signed [SAMPLE_W-1:0] a,
                                              logic signed [SAMPLE_W-1:0] b,
                                              longint frac);
      longint acc;
      acc = longint'(a) * PHASE_ONE + (longint'(b) - longint'(a)) * frac;
      return SAMPLE_W'((acc + PHASE_HALF) >>> FRAC_W);
    endfunction

    function void take_sample(logic signed [SAMPLE_W-1:0] s, logic last);
      longint     step;
      resampled_t burst[$];
      resampled_t r;
      step = (longint'(step_reg) < STEP_FLOOR) ? STEP_FLOOR : longint'(step_reg);
      r.run_last = 1'b0;
      r.clip_end = 1'b0;
      if (!primed) begin
        // first sample of a clip only seeds the interval
        prev_sample = s;
        primed      = 1'b1;
        cursor      = 0;
      end else begin
        while (cursor < PHASE_ONE && burst.size() < MAX_PER_INPUT) begin
          r.sample = blend(prev_sample, s, cursor);
          burst.insert(burst.size(), r);
          cursor += step;
        end
        cursor      = (cursor >= PHASE_ONE) ? cursor - PHASE_ONE : 0;
        prev_sample = s;
      end
      if (last) begin
        // end clamp: positions in [s, s+1) repeat s
        while (cursor < PHASE_ONE && burst.size() < MAX_PER_INPUT) begin
          r.sample = s;
          burst.insert(burst.size(), r);
          cursor += step;
        end
        prev_sample = '0;
        primed      = 1'b0;
        cursor      = 0;
      end
      if (burst.size() > 0) begin
        r          = burst[burst.size()-1];
        r.run_last = 1'b1;
        r.clip_end = last;
        burst[burst.size()-1] = r;
      end
      pending_outs = {pending_outs, burst};
    endfunction

    // Returns 1 on a match; otherwise why holds the reason.
    function bit check_output(resampled_t got, output string why);
      resampled_t want;
      why = "";
      if (pending_outs.size() == 0) begin
        why = $sformatf("unexpected output sample=%0d run_last=%0b clip_end=%0b",
                        got.sample, got.run_last, got.clip_end);
        return 1'b0;
      end
      want = pending_outs.pop_front();
      if (got.sample !== want.sample)
        why = {why, $sformatf(" sample got %0d want %0d", got.sample, want.sample)};
      if (got.run_last !== want.run_last)
        why = {why, $sformatf(" run_last got %0b want %0b", got.run_last, want.run_last)};
      if (got.clip_end !== want.clip_end)
        why = {why, $sformatf(" clip_end got %0b want %0b", got.clip_end, want.clip_end)};
      return (why == "");
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels, DUT
  // --------------------------------------------------------------------------
  logic clk;
  logic rst_n;

  lir_in_if  #(.SAMPLE_BITS(SAMPLE_W)) in_if ();
  lir_out_if #(.SAMPLE_BITS(SAMPLE_W)) out_if ();
  lir_cfg_if #(.STEP_BITS(STEP_W))     cfg_if ();

  linear_interp_resampler #(
    .SAMPLE_BITS    (SAMPLE_W),
    .PHASE_FRAC_BITS(FRAC_W)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if.sink),
    .out_chan(out_if.source),
    .cfg_chan(cfg_if.sink)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  resampler_scoreboard sb = new();

  int err_count   = 0;
  int quiet_count = 0;    // cycles since the last transfer on any channel
  bit idle_on     = 1'b1; // random idling on both sides
  bit hold_request = 1'b0;

  task automatic report(input string msg);
    err_count++;
    // keep the log bounded if the block is badly broken
    if (err_count <= 40) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // --------------------------------------------------------------------------
  // Monitor: everything is sampled on the rising edge; inputs move only on the
  // falling edge, so the sampled values never race the DUT.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    resampled_t got;
    string      why;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) sb.set_rate(cfg_if.rate_step);
      if (in_if.valid && in_if.ready) sb.take_sample(in_if.sample_in, in_if.last_in);
      if (out_if.valid && out_if.ready) begin
        got.sample   = out_if.sample_out;
        got.run_last = out_if.run_last;
        got.clip_end = out_if.clip_end;
        if (!sb.check_output(got, why)) report(why);
      end
    end
  end

  // Watchdog: trips only if no transfer happens on any channel for too long.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || !rst_n) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
      if (quiet_count >= STALL_LIMIT) begin
        $display("[%0t] watchdog: no transfer for %0d cycles, %0d outputs pending",
                 $realtime, STALL_LIMIT, sb.outstanding());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random back-pressure, plus one long hold-off on request so the
  // block fills up and pushes back on its input.
  // --------------------------------------------------------------------------
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_if.ready = !(idle_on && $urandom_range(99) < IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Sender side. Every task starts and ends on a falling edge.
  // --------------------------------------------------------------------------
  // One sample transfer; valid stays high into the next call for back-to-back.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic last);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid     = 1'b1;
    in_if.sample_in = s;
    in_if.last_in   = last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering input and let every predicted output drain, then allow for
  // an input still in flight that produces nothing (downsampling tail).
  task automatic drain();
    in_if.valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write; only ever issued with the block drained.
  task automatic write_rate(input logic [STEP_W-1:0] v);
    cfg_if.valid     = 1'b1;
    cfg_if.rate_step = v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  function automatic logic [STEP_W-1:0] pick_rate();
    logic [STEP_W-1:0] v;
    case ($urandom_range(9)) inside
      0:       v = STEP_W'($urandom_range(4095));        // below floor, clamped
      1:       v = 20'd4096;                             // 16x upsample
      2:       v = 20'hFFFFF;                            // heaviest downsample
      [3:4]:   v = STEP_W'($urandom_range(65536, 4096)); // upsampling
      [5:6]:   v = STEP_W'($urandom_range(262144, 65536));
      7:       v = STEP_W'($urandom_range(1048575, 262144));
      default: v = STEP_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic signed [SAMPLE_W-1:0] v;
    case ($urandom_range(7))
      0:       v = 16'sh8000;                                // most negative
      1:       v = 16'sh7FFF;                                // most positive
      2:       v = SAMPLE_W'(int'($urandom_range(8)) - 4);   // tiny steps hit ties
      default: v = SAMPLE_W'($urandom);
    endcase
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int clip_left;
    in_if.valid      = 1'b0;
    in_if.sample_in  = '0;
    in_if.last_in    = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.rate_step = '0;
    rst_n            = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset rate of 1.0, one output per interval; field extremes;
    // a clip of one sample flushes that sample once.
    send_sample(16'sd0,      1'b0);   // seed only, no output
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd32767,  1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd1,      1'b1);
    send_sample(16'sd1234,   1'b1);   // single-sample clip

    // Half step: midpoints, ties round up (0..1 -> 1, 0..-1 -> 0).
    drain();
    write_rate(20'd32768);
    send_sample(16'sd0,      1'b0);
    send_sample(16'sd1,      1'b0);
    send_sample(16'sd0,      1'b0);
    send_sample(-16'sd1,     1'b0);
    send_sample(16'sd32767,  1'b0);
    send_sample(-16'sd32768, 1'b1);

    // Zero step is clamped to 1/16: 16 outputs per interval, 16 on flush.
    drain();
    write_rate(20'd0);
    send_sample(16'sd100,  1'b0);
    send_sample(-16'sd100, 1'b0);
    send_sample(16'sd5,    1'b1);
    send_sample(16'sd7,    1'b1);

    // Largest step: outputs are rare and the last sample produces none.
    drain();
    write_rate(20'hFFFFF);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd2, 1'b0);
    send_sample(16'sd3, 1'b0);
    send_sample(16'sd4, 1'b1);

    // Random clips. A phase may end mid-clip, so the rate also changes
    // inside an open clip.
    clip_left = 0;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      idle_on = (ph != QUIET_PHASE);
      write_rate((ph == HOLD_PHASE) ? 20'd16384 : pick_rate());
      if (ph == HOLD_PHASE) hold_request = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (clip_left == 0)
          clip_left = ($urandom_range(9) == 0) ? 1 : $urandom_range(24, 2);
        send_sample(pick_sample(), clip_left == 1);
        clip_left--;
      end
    end

    drain();
    idle_on = 1'b1;
    repeat (TAIL_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
